// ===== design/bfgp_pkg.sv =====
// Shared types and constants for the grid planner.
// Used by the controller, the datapath and the top level; depends on nothing.
package bfgp_pkg;

   // Grid geometry: cell id = {row, column}
   localparam int X_BITS  = 6;
   localparam int Y_BITS  = 6;
   localparam int ID_BITS = X_BITS + Y_BITS;
   localparam int LEN_BITS = ID_BITS + 1;
   localparam int DIM_BITS = 7;
   localparam logic [DIM_BITS-1:0] MAX_DIM = 7'd64;

   // Cost arithmetic
   localparam int COST_BITS = 16;
   localparam logic [COST_BITS-1:0] COST_INF = '1;
   localparam logic [COST_BITS-1:0] COST_SAT = COST_INF - 16'd1;
   localparam logic [7:0] BLOCK_LEVEL = 8'd254;

   // Request opcodes
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_PLAN = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // Response status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_UNREACH = 2'd1;
   localparam logic [1:0] STAT_EMPTY   = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_WIDTH    = 2'd0;
   localparam logic [1:0] REG_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_STRAIGHT = 2'd2;
   localparam logic [1:0] REG_DIAGONAL = 2'd3;

   // Neighbor offsets in relaxation order
   localparam logic [1:0] STEP_DX [8] = '{2'b00, 2'b01, 2'b00, 2'b11,
                                          2'b01, 2'b01, 2'b11, 2'b11};
   localparam logic [1:0] STEP_DY [8] = '{2'b01, 2'b00, 2'b11, 2'b00,
                                          2'b01, 2'b11, 2'b01, 2'b11};

   typedef enum logic [3:0] {
      ST_IDLE, ST_CLEAR, ST_SEED, ST_SCAN_RD, ST_SCAN_C, ST_NB_CHK, ST_NB_EVAL,
      ST_NEXT, ST_GOAL_RD, ST_GOAL_C, ST_CNT, ST_CNT_W, ST_WR, ST_WR_W,
      ST_RD1, ST_RD2
   } state_type;

   typedef enum logic [1:0] {
      CSRC_CELL, CSRC_NB, CSRC_GOAL, CSRC_PATH
   } cost_src_type;

   typedef enum logic [2:0] {
      RSP_ZERO, RSP_UNREACH, RSP_EMPTY, RSP_PLAN_OK, RSP_READ
   } rsp_kind_type;

   typedef struct packed {
      logic         load_wr;
      logic         plan_init;
      logic         clr_step;
      logic         seed;
      cost_src_type cost_src;
      logic         cell_load;
      logic         nb_eval;
      logic         k_step;
      logic         cell_next;
      logic         trace_init;
      logic         cnt_step;
      logic         wr_init;
      logic         wr_path;
      logic         wr_step;
      logic         commit;
      logic         rd_step;
      logic         emit;
      rsp_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic path_avail;
      logic clr_last;
      logic range_bad;
      logic one_cell;
      logic cell_inf;
      logic nb_out;
      logic k_last;
      logic run_done;
      logic goal_inf;
      logic at_start;
      logic len_over;
      logic widx_zero;
   } dp_stat_type;

endpackage

// ===== design/bfgp_controller.sv =====
// Sequencer for the grid planner: handshake control and datapath commands.
// Depends on bfgp_pkg.
module bfgp_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_op,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bfgp_pkg::dp_stat_type stat,
   output bfgp_pkg::dp_cmd_type  cmd
);
   import bfgp_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // State and response flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready    = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept       = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.cost_src = CSRC_CELL;
      cmd.kind     = RSP_ZERO;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority if (req_op == OP_LOAD) begin
                  cmd.load_wr = 1'b1;
                  cmd.emit    = 1'b1;
               end else if (req_op == OP_PLAN) begin
                  cmd.plan_init = 1'b1;
                  state_in      = ST_CLEAR;
               end else if (req_op == OP_READ) begin
                  if (stat.path_avail) begin
                     state_in = ST_RD1;
                  end else begin
                     cmd.emit = 1'b1;
                     cmd.kind = RSP_EMPTY;
                  end
               end else begin
                  cmd.emit = 1'b1;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               if (stat.range_bad) begin
                  cmd.emit = 1'b1;
                  cmd.kind = RSP_UNREACH;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SEED;
               end
            end
         end
         ST_SEED: begin
            cmd.seed = 1'b1;
            state_in = stat.one_cell ? ST_GOAL_RD : ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            cmd.cost_src = CSRC_CELL;
            state_in     = ST_SCAN_C;
         end
         ST_SCAN_C: begin
            if (stat.cell_inf) begin
               state_in = ST_NEXT;
            end else begin
               cmd.cell_load = 1'b1;
               state_in      = ST_NB_CHK;
            end
         end
         ST_NB_CHK: begin
            cmd.cost_src = CSRC_NB;
            if (stat.nb_out) begin
               cmd.k_step = 1'b1;
               if (stat.k_last) state_in = ST_NEXT;
            end else begin
               state_in = ST_NB_EVAL;
            end
         end
         ST_NB_EVAL: begin
            cmd.nb_eval = 1'b1;
            cmd.k_step  = 1'b1;
            state_in    = stat.k_last ? ST_NEXT : ST_NB_CHK;
         end
         ST_NEXT: begin
            cmd.cell_next = 1'b1;
            state_in      = stat.run_done ? ST_GOAL_RD : ST_SCAN_RD;
         end
         ST_GOAL_RD: begin
            cmd.cost_src = CSRC_GOAL;
            state_in     = ST_GOAL_C;
         end
         ST_GOAL_C: begin
            if (stat.goal_inf) begin
               cmd.emit = 1'b1;
               cmd.kind = RSP_UNREACH;
               state_in = ST_IDLE;
            end else begin
               cmd.trace_init = 1'b1;
               state_in       = ST_CNT;
            end
         end
         ST_CNT: begin
            priority if (stat.at_start) begin
               cmd.wr_init = 1'b1;
               state_in    = ST_WR;
            end else if (stat.len_over) begin
               cmd.emit = 1'b1;
               cmd.kind = RSP_UNREACH;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_CNT_W;
            end
         end
         ST_CNT_W: begin
            cmd.cnt_step = 1'b1;
            state_in     = ST_CNT;
         end
         ST_WR: begin
            cmd.wr_path = 1'b1;
            if (stat.widx_zero) begin
               cmd.commit = 1'b1;
               cmd.emit   = 1'b1;
               cmd.kind   = RSP_PLAN_OK;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_WR_W;
            end
         end
         ST_WR_W: begin
            cmd.wr_step = 1'b1;
            state_in    = ST_WR;
         end
         ST_RD1: begin
            cmd.cost_src = CSRC_PATH;
            state_in     = ST_RD2;
         end
         ST_RD2: begin
            cmd.rd_step = 1'b1;
            cmd.emit    = 1'b1;
            cmd.kind    = RSP_READ;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== design/bfgp_datapath.sv =====
// Datapath for the grid planner: grid memories, scan counters, relaxation
// arithmetic, traceback and the response register. Depends on bfgp_pkg.
module bfgp_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [5:0]           req_cell_x,
   input  logic [5:0]           req_cell_y,
   input  logic [7:0]           req_occupancy,
   input  logic [5:0]           req_goal_x,
   input  logic [5:0]           req_goal_y,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata,
   input  bfgp_pkg::dp_cmd_type  cmd,
   output bfgp_pkg::dp_stat_type stat,
   output logic [1:0]           rsp_status,
   output logic [5:0]           rsp_path_x,
   output logic [5:0]           rsp_path_y,
   output logic [15:0]          rsp_path_cost,
   output logic                 rsp_last
);
   import bfgp_pkg::*;

   localparam int CELLS = 1 << ID_BITS;

   // Memories
   logic [7:0]           occ_mem  [CELLS];
   logic [COST_BITS-1:0] cost_mem [CELLS];
   logic [ID_BITS-1:0]   pred_mem [CELLS];
   logic [ID_BITS-1:0]   path_mem [CELLS];
   logic [7:0]           occ_q_ff;
   logic [COST_BITS-1:0] cost_q_ff;
   logic [ID_BITS-1:0]   pred_q_ff;
   logic [ID_BITS-1:0]   path_q_ff;

   // Configuration
   logic [DIM_BITS-1:0] width_ff, height_ff;
   logic [7:0]          straight_ff, diagonal_ff;

   // Plan and scan state
   logic [X_BITS-1:0]    sx_ff, gx_ff, x_ff;
   logic [Y_BITS-1:0]    sy_ff, gy_ff, y_ff;
   logic [2:0]           k_ff;
   logic [COST_BITS-1:0] c_ff, goal_cost_ff;
   logic                 changed_ff;
   logic [ID_BITS-1:0]   pass_ff, clr_ff, cur_ff, widx_ff;
   logic [LEN_BITS-1:0]  len_ff, path_len_ff, rd_ptr_ff;

   logic [DIM_BITS-1:0]  w, h;
   logic [7:0]           sc, dc, step;
   logic [13:0]          area;
   logic [LEN_BITS-1:0]  cells;
   logic [ID_BITS-1:0]   cell_id, start_id, goal_id, nb_id;
   logic [7:0]           nx, ny;
   logic [1:0]           dx, dy;
   logic [COST_BITS:0]   sum;
   logic [COST_BITS-1:0] nc;
   logic                 improve, scan_last, row_last;
   logic [ID_BITS-1:0]   cost_raddr;

   // Clamp the configuration
   always_comb begin
      w  = (width_ff == '0) ? 7'd1 : ((width_ff > MAX_DIM) ? MAX_DIM : width_ff);
      h  = (height_ff == '0) ? 7'd1 : ((height_ff > MAX_DIM) ? MAX_DIM : height_ff);
      sc = (straight_ff == '0) ? 8'd1 : straight_ff;
      dc = (diagonal_ff == '0) ? 8'd1 : diagonal_ff;
      area  = {7'd0, w} * {7'd0, h};
      cells = area[LEN_BITS-1:0];
   end

   assign cell_id  = {y_ff, x_ff};
   assign start_id = {sy_ff, sx_ff};
   assign goal_id  = {gy_ff, gx_ff};

   // Neighbor address and relaxed cost
   always_comb begin
      dx      = STEP_DX[k_ff];
      dy      = STEP_DY[k_ff];
      nx      = {2'b00, x_ff} + {{6{dx[1]}}, dx};
      ny      = {2'b00, y_ff} + {{6{dy[1]}}, dy};
      nb_id   = {ny[Y_BITS-1:0], nx[X_BITS-1:0]};
      step    = k_ff[2] ? dc : sc;
      sum     = {1'b0, c_ff} + {9'd0, step};
      nc      = (sum > {1'b0, COST_SAT}) ? COST_SAT : sum[COST_BITS-1:0];
      improve = (occ_q_ff < BLOCK_LEVEL) && (nc < cost_q_ff);
   end

   assign row_last  = ({1'b0, x_ff} == w - 7'd1);
   assign scan_last = row_last && ({1'b0, y_ff} == h - 7'd1);

   // Status to the controller
   always_comb begin
      stat.path_avail = rd_ptr_ff < path_len_ff;
      stat.clr_last   = &clr_ff;
      stat.range_bad  = ({1'b0, sx_ff} >= w) || ({1'b0, sy_ff} >= h) ||
                        ({1'b0, gx_ff} >= w) || ({1'b0, gy_ff} >= h);
      stat.one_cell   = cells == 13'd1;
      stat.cell_inf   = cost_q_ff == COST_INF;
      stat.nb_out     = nx[7] || ny[7] || (nx[6:0] >= w) || (ny[6:0] >= h);
      stat.k_last     = &k_ff;
      stat.run_done   = scan_last &&
                        (!changed_ff || ({1'b0, pass_ff} + 13'd1 == cells - 13'd1));
      stat.goal_inf   = cost_q_ff == COST_INF;
      stat.at_start   = cur_ff == start_id;
      stat.len_over   = len_ff > cells;
      stat.widx_zero  = widx_ff == '0;
   end

   // Select the cost read address
   always_comb begin
      unique case (cmd.cost_src)
         CSRC_CELL: cost_raddr = cell_id;
         CSRC_NB:   cost_raddr = nb_id;
         CSRC_GOAL: cost_raddr = goal_id;
         CSRC_PATH: cost_raddr = path_q_ff;
         default:   cost_raddr = cell_id;
      endcase
   end

   // Occupancy memory
   always_ff @(posedge clock) begin
      if (cmd.load_wr) occ_mem[{req_cell_y, req_cell_x}] <= req_occupancy;
      occ_q_ff <= occ_mem[nb_id];
   end

   // Cost memory: clear, seed, relax
   always_ff @(posedge clock) begin
      priority if (cmd.clr_step) begin
         cost_mem[clr_ff] <= COST_INF;
      end else if (cmd.seed) begin
         cost_mem[start_id] <= '0;
      end else if (cmd.nb_eval && improve) begin
         cost_mem[nb_id] <= nc;
      end
      cost_q_ff <= cost_mem[cost_raddr];
   end

   // Predecessor memory
   always_ff @(posedge clock) begin
      if (cmd.nb_eval && improve) pred_mem[nb_id] <= cell_id;
      pred_q_ff <= pred_mem[cur_ff];
   end

   // Path memory
   always_ff @(posedge clock) begin
      if (cmd.wr_path) path_mem[widx_ff] <= cur_ff;
      path_q_ff <= path_mem[rd_ptr_ff[ID_BITS-1:0]];
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= MAX_DIM;
         height_ff   <= MAX_DIM;
         straight_ff <= 8'd10;
         diagonal_ff <= 8'd14;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WIDTH:    width_ff    <= csr_wdata[DIM_BITS-1:0];
            REG_HEIGHT:   height_ff   <= csr_wdata[DIM_BITS-1:0];
            REG_STRAIGHT: straight_ff <= csr_wdata;
            REG_DIAGONAL: diagonal_ff <= csr_wdata;
            default:      width_ff    <= width_ff;
         endcase
      end
   end

   // Path bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         path_len_ff <= '0;
         rd_ptr_ff   <= '0;
      end else begin
         if (cmd.plan_init) begin
            path_len_ff <= '0;
            rd_ptr_ff   <= '0;
         end
         if (cmd.commit) path_len_ff <= len_ff;
         if (cmd.rd_step) rd_ptr_ff <= rd_ptr_ff + 13'd1;
      end
   end

   // Plan, scan and trace registers
   always_ff @(posedge clock) begin
      if (cmd.plan_init) begin
         sx_ff  <= req_cell_x;
         sy_ff  <= req_cell_y;
         gx_ff  <= req_goal_x;
         gy_ff  <= req_goal_y;
         clr_ff <= '0;
      end
      if (cmd.clr_step) clr_ff <= clr_ff + 12'd1;
      if (cmd.seed) begin
         x_ff       <= '0;
         y_ff       <= '0;
         pass_ff    <= '0;
         changed_ff <= 1'b0;
      end
      if (cmd.cell_load) begin
         c_ff <= cost_q_ff;
         k_ff <= '0;
      end
      if (cmd.k_step) k_ff <= k_ff + 3'd1;
      if (cmd.nb_eval && improve) changed_ff <= 1'b1;
      if (cmd.cell_next) begin
         if (scan_last) begin
            x_ff       <= '0;
            y_ff       <= '0;
            pass_ff    <= pass_ff + 12'd1;
            changed_ff <= 1'b0;
         end else if (row_last) begin
            x_ff <= '0;
            y_ff <= y_ff + 6'd1;
         end else begin
            x_ff <= x_ff + 6'd1;
         end
      end
      if (cmd.trace_init) begin
         goal_cost_ff <= cost_q_ff;
         cur_ff       <= goal_id;
         len_ff       <= 13'd1;
      end
      if (cmd.cnt_step) begin
         cur_ff <= pred_q_ff;
         len_ff <= len_ff + 13'd1;
      end
      if (cmd.wr_init) begin
         cur_ff  <= goal_id;
         widx_ff <= len_ff[ID_BITS-1:0] - 12'd1;
      end
      if (cmd.wr_step) begin
         cur_ff  <= pred_q_ff;
         widx_ff <= widx_ff - 12'd1;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status    <= STAT_OK;
         rsp_path_x    <= '0;
         rsp_path_y    <= '0;
         rsp_path_cost <= '0;
         rsp_last      <= 1'b0;
         unique case (cmd.kind)
            RSP_ZERO: ;
            RSP_UNREACH: begin
               rsp_status    <= STAT_UNREACH;
               rsp_path_cost <= COST_INF;
            end
            RSP_EMPTY: rsp_status <= STAT_EMPTY;
            RSP_PLAN_OK: rsp_path_cost <= goal_cost_ff;
            RSP_READ: begin
               rsp_path_x    <= path_q_ff[X_BITS-1:0];
               rsp_path_y    <= path_q_ff[ID_BITS-1:X_BITS];
               rsp_path_cost <= cost_q_ff;
               rsp_last      <= (rd_ptr_ff + 13'd1) == path_len_ff;
            end
            default: ;
         endcase
      end
   end

endmodule

// ===== design/bellman_ford_grid_planner.sv =====
// Top level of the grid shortest-path planner.
// Instantiates bfgp_controller and bfgp_datapath; depends on bfgp_pkg.
//
// Usage:
//  - Requests on req_*, one response each on rsp_* (both valid/ready). The
//    user writes csr_* registers only while idle; not enforced by the block.
//  - Load (op 0) stores an occupancy byte and responds in the next cycle.
//  - Read (op 2) returns the next path cell, start first, once the path
//    memory read and then the cost memory read are done.
//  - Plan (op 1) first clears the whole cost memory (one word a cycle),
//    then each relaxation pass visits every cell in use and, for a reached
//    cell, checks and relaxes each of its eight neighbors in turn. Passes
//    stop after one with no change or after (cells in use - 1) passes.
//    Traceback walks back from the goal to count the path, then to write it.
//  - One request is in work at a time; a new one is taken only once the
//    previous response has been taken or is being taken in the same cycle.
//  - Reset empties the path, restores the register defaults and drops any
//    pending response. The occupancy grid holds garbage until loaded.
//  - A pending response holds while rsp_ready is low; no request is taken.
module bellman_ford_grid_planner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [5:0]  req_cell_x,
   input  logic [5:0]  req_cell_y,
   input  logic [7:0]  req_occupancy,
   input  logic [5:0]  req_goal_x,
   input  logic [5:0]  req_goal_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_path_x,
   output logic [5:0]  rsp_path_y,
   output logic [15:0] rsp_path_cost,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import bfgp_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer
   bfgp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Memories and arithmetic
   bfgp_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .req_occupancy (req_occupancy),
      .req_goal_x    (req_goal_x),
      .req_goal_y    (req_goal_y),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_status    (rsp_status),
      .rsp_path_x    (rsp_path_x),
      .rsp_path_y    (rsp_path_y),
      .rsp_path_cost (rsp_path_cost),
      .rsp_last      (rsp_last)
   );

   // A plan request keeps the block busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_op == OP_PLAN) |=> !req_ready)
      else $error("plan request did not make the block busy");

   // The goal marker only comes with a good read
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_status == STAT_OK))
      else $error("last flag on a failed response");

   // An unreachable goal reports infinite cost
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STAT_UNREACH) |-> (rsp_path_cost == COST_INF))
      else $error("unreachable response without infinite cost");

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for bellman_ford_grid_planner: directed table, then random requests.
// Own shortest-path planner predicts all but typed rows; depends on bfgp_pkg and the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import bfgp_pkg::*;

   // opcode with no function
   localparam logic [1:0] OP_SPARE = 2'd3;

   typedef struct {
      bit          is_csr;
      logic [1:0]  csr_idx;
      logic [7:0]  csr_val;
      logic [1:0]  op;
      logic [5:0]  cx, cy;
      logic [7:0]  occ;
      logic [5:0]  gx, gy;
      bit          typed;
      logic [1:0]  status;
      logic [5:0]  px, py;
      logic [15:0] cost;
      logic        last;
   } step_row_type;

   typedef struct {
      logic [1:0]  status;
      logic [5:0]  px, py;
      logic [15:0] cost;
      logic        last;
   } route_rsp_type;

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, rsp_ready = 0, csr_we = 0;
   logic [1:0]  req_op = 0, csr_index = 0;
   logic [5:0]  req_cell_x = 0, req_cell_y = 0, req_goal_x = 0, req_goal_y = 0;
   logic [7:0]  req_occupancy = 0, csr_wdata = 0;
   logic        req_ready, rsp_valid, rsp_last;
   logic [1:0]  rsp_status;
   logic [5:0]  rsp_path_x, rsp_path_y;
   logic [15:0] rsp_path_cost;

   bellman_ford_grid_planner dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      #200ms;
      $display("tb: failure");
      $finish;
   end

   // planner mirror
   logic [6:0]  grid_w = 64, grid_h = 64;
   logic [7:0]  step_straight = 10, step_diag = 14;
   logic [7:0]  occ_grid [4096];
   logic [15:0] cost_map [4096];
   int          pred_cell [4096];
   int          route [4096];
   int          route_len = 0, read_ptr = 0;

   route_rsp_type pending_rsp [$];
   int          errors = 0, plans = 0, reads = 0, loads = 0;
   bit          calm = 0;

   function automatic int clamp_dim(logic [6:0] v);
      if (v == 0) return 1;
      return (v > 64) ? 64 : int'(v);
   endfunction

   // run the relaxation passes and the traceback; returns the status code
   function automatic logic [1:0] plan_route(int sx, int sy, int gx, int gy,
                                             output logic [15:0] goal_cost);
      int w, h, sc, dc, start, goal, cur, len, id, nx, ny, nid, nc;
      bit changed;
      int dxs [8] = '{0, 1, 0, -1, 1, 1, -1, -1};
      int dys [8] = '{1, 0, -1, 0, 1, -1, 1, -1};
      w = clamp_dim(grid_w);
      h = clamp_dim(grid_h);
      sc = (step_straight == 0) ? 1 : int'(step_straight);
      dc = (step_diag == 0) ? 1 : int'(step_diag);
      route_len = 0;
      read_ptr = 0;
      goal_cost = COST_INF;
      for (int i = 0; i < 4096; i++) begin
         cost_map[i] = COST_INF;
         pred_cell[i] = 0;
      end
      if (sx >= w || sy >= h || gx >= w || gy >= h) return STAT_UNREACH;
      start = sy * 64 + sx;
      goal = gy * 64 + gx;
      cost_map[start] = 0;
      for (int p = 0; p < w * h - 1; p++) begin
         changed = 0;
         for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
               id = y * 64 + x;
               if (cost_map[id] == COST_INF) continue;
               for (int k = 0; k < 8; k++) begin
                  nx = x + dxs[k];
                  ny = y + dys[k];
                  if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
                  nid = ny * 64 + nx;
                  if (occ_grid[nid] >= BLOCK_LEVEL) continue;
                  nc = int'(cost_map[id]) + ((k < 4) ? sc : dc);
                  if (nc > int'(COST_SAT)) nc = int'(COST_SAT);
                  if (nc < int'(cost_map[nid])) begin
                     cost_map[nid] = 16'(nc);
                     pred_cell[nid] = id;
                     changed = 1;
                  end
               end
            end
         if (!changed) break;
      end
      if (cost_map[goal] == COST_INF) return STAT_UNREACH;
      len = 1;
      cur = goal;
      while (cur != start) begin
         if (len > w * h) return STAT_UNREACH;
         cur = pred_cell[cur] % 4096;
         len++;
      end
      cur = goal;
      for (int i = 0; i < len; i++) begin
         route[len - 1 - i] = cur;
         cur = pred_cell[cur] % 4096;
      end
      route_len = len;
      goal_cost = cost_map[goal];
      return STAT_OK;
   endfunction

   // advance the mirror by one request and return its response
   function automatic route_rsp_type predict_rsp(step_row_type r);
      route_rsp_type e = '{STAT_OK, 0, 0, 0, 0};
      int id;
      case (r.op)
         OP_LOAD: begin
            occ_grid[r.cy * 64 + r.cx] = r.occ;
            loads++;
         end
         OP_PLAN: begin
            e.status = plan_route(r.cx, r.cy, r.gx, r.gy, e.cost);
            plans++;
         end
         OP_READ: begin
            reads++;
            if (read_ptr < route_len) begin
               id = route[read_ptr];
               e.px = 6'(id % 64);
               e.py = 6'(id / 64);
               e.cost = cost_map[id];
               e.last = (read_ptr + 1 == route_len);
               read_ptr++;
            end else
               e.status = STAT_EMPTY;
         end
         default: ;
      endcase
      return e;
   endfunction

   task automatic report(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
   endtask

   // check each response against the oldest expected one
   always @(posedge clock) begin
      route_rsp_type e;
      if (reset)
         rsp_ready <= 0;
      else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0)
               report("unexpected response status", rsp_status, -1);
            else begin
               e = pending_rsp.pop_front();
               if (rsp_status !== e.status) report("status", rsp_status, e.status);
               if (rsp_path_x !== e.px) report("path_x", rsp_path_x, e.px);
               if (rsp_path_y !== e.py) report("path_y", rsp_path_y, e.py);
               if (rsp_path_cost !== e.cost) report("path_cost", rsp_path_cost, e.cost);
               if (rsp_last !== e.last) report("last", rsp_last, e.last);
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 26);
      end
   end

   // send one request; hold valid and payload until accepted
   task automatic send_request(step_row_type r);
      route_rsp_type e;
      while (!calm && $urandom_range(99) < 26) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_op <= r.op;
      req_cell_x <= r.cx;
      req_cell_y <= r.cy;
      req_occupancy <= r.occ;
      req_goal_x <= r.gx;
      req_goal_y <= r.gy;
      do @(posedge clock); while (!req_ready);
      e = predict_rsp(r);
      if (r.typed) e = '{r.status, r.px, r.py, r.cost, r.last};
      pending_rsp.push_back(e);
   endtask

   // drain all responses, then write one register
   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      req_valid <= 0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         REG_WIDTH:    grid_w = val[6:0];
         REG_HEIGHT:   grid_h = val[6:0];
         REG_STRAIGHT: step_straight = val;
         default:      step_diag = val;
      endcase
   endtask

   function automatic step_row_type req_row(logic [1:0] op, int cx, int cy, int occ,
                                            int gx, int gy);
      step_row_type r = '{default: 0};
      r.op = op; r.cx = 6'(cx); r.cy = 6'(cy); r.occ = 8'(occ);
      r.gx = 6'(gx); r.gy = 6'(gy);
      return r;
   endfunction

   function automatic step_row_type typed_row(step_row_type r, logic [1:0] st, int px,
                                              int py, int cost, logic last);
      r.typed = 1; r.status = st; r.px = 6'(px); r.py = 6'(py); r.cost = 16'(cost);
      r.last = last;
      return r;
   endfunction

   function automatic step_row_type csr_row(logic [1:0] idx, logic [7:0] val);
      step_row_type r = '{default: 0};
      r.is_csr = 1; r.csr_idx = idx; r.csr_val = val;
      return r;
   endfunction

   function automatic logic [7:0] rand_occ();
      return ($urandom_range(99) < 12) ? 8'($urandom_range(254, 255)) : 8'($urandom_range(253));
   endfunction

   step_row_type directed [$];

   initial begin
      step_row_type r;
      int w, h, pick;
      repeat (3) @(posedge clock);
      reset <= 0;

      // a read after reset finds no path; the unused opcode answers all zero
      send_request(typed_row(req_row(OP_READ, 0, 0, 0, 0, 0), STAT_EMPTY, 0, 0, 0, 0));
      send_request(typed_row(req_row(OP_SPARE, 63, 63, 255, 63, 63), STAT_OK, 0, 0, 0, 0));

      // fill every cell that a plan can reach: the small corner, row zero and column zero
      for (int y = 0; y < 64; y++)
         for (int x = 0; x < 64; x++)
            if ((x < 8 && y < 8) || x == 0 || y == 0)
               send_request(req_row(OP_LOAD, x, y, rand_occ(), 0, 0));

      // zero dimensions count as one: a single-cell plan
      directed.push_back(csr_row(REG_WIDTH, 0));
      directed.push_back(csr_row(REG_HEIGHT, 0));
      directed.push_back(typed_row(req_row(OP_LOAD, 0, 0, 255, 0, 0), STAT_OK, 0, 0, 0, 0));
      directed.push_back(typed_row(req_row(OP_PLAN, 0, 0, 0, 0, 0), STAT_OK, 0, 0, 0, 0));
      directed.push_back(typed_row(req_row(OP_READ, 0, 0, 0, 0, 0), STAT_OK, 0, 0, 0, 1));
      directed.push_back(typed_row(req_row(OP_READ, 0, 0, 0, 0, 0), STAT_EMPTY, 0, 0, 0, 0));
      // start outside the grid in use
      directed.push_back(typed_row(req_row(OP_PLAN, 1, 0, 0, 0, 0),
                                   STAT_UNREACH, 0, 0, 16'hFFFF, 0));
      // widest single row, extreme step costs, blocked start
      directed.push_back(csr_row(REG_WIDTH, 127));
      directed.push_back(csr_row(REG_STRAIGHT, 255));
      directed.push_back(csr_row(REG_DIAGONAL, 0));
      for (int x = 1; x < 64; x++) occ_grid[x] = 8'd0;
      directed.push_back(req_row(OP_LOAD, 63, 0, 253, 0, 0));
      directed.push_back(req_row(OP_LOAD, 1, 0, 0, 0, 0));
      directed.push_back(req_row(OP_PLAN, 0, 0, 0, 63, 0));
      directed.push_back(req_row(OP_READ, 0, 0, 0, 0, 0));
      directed.push_back(req_row(OP_READ, 0, 0, 0, 0, 0));
      // tallest single column, goal blocked
      directed.push_back(csr_row(REG_WIDTH, 1));
      directed.push_back(csr_row(REG_HEIGHT, 64));
      directed.push_back(csr_row(REG_STRAIGHT, 1));
      directed.push_back(csr_row(REG_DIAGONAL, 255));
      directed.push_back(req_row(OP_LOAD, 0, 63, 254, 0, 0));
      directed.push_back(typed_row(req_row(OP_PLAN, 0, 0, 0, 0, 63),
                                   STAT_UNREACH, 0, 0, 16'hFFFF, 0));
      directed.push_back(typed_row(req_row(OP_READ, 0, 0, 0, 0, 0), STAT_EMPTY, 0, 0, 0, 0));
      directed.push_back(req_row(OP_LOAD, 0, 63, 0, 0, 0));
      directed.push_back(req_row(OP_PLAN, 0, 63, 0, 0, 0));
      directed.push_back(req_row(OP_READ, 0, 0, 0, 0, 0));

      // the loop above cleared the row-zero mirror; load the same zeros into the block
      for (int x = 1; x < 64; x++)
         if (x != 1 && x != 63) directed.push_front(req_row(OP_LOAD, x, 0, 0, 0, 0));

      foreach (directed[i]) begin
         if (directed[i].is_csr) write_reg(directed[i].csr_idx, directed[i].csr_val);
         else send_request(directed[i]);
      end

      // random phases, each with its own grid size and step costs
      for (int phase = 0; phase < 13; phase++) begin
         write_reg(REG_STRAIGHT, 8'($urandom_range(255)));
         write_reg(REG_DIAGONAL, 8'($urandom_range(255)));
         if (phase == 7) begin
            write_reg(REG_WIDTH, 1);
            write_reg(REG_HEIGHT, 127);
         end else begin
            write_reg(REG_WIDTH, ($urandom_range(9) == 0) ? 8'd8 : 8'($urandom_range(1, 6)));
            write_reg(REG_HEIGHT, ($urandom_range(9) == 0) ? 8'd8 : 8'($urandom_range(1, 6)));
         end
         w = clamp_dim(grid_w);
         h = clamp_dim(grid_h);
         calm = (phase == 5 || phase == 6);
         for (int n = 0; n < 100; n++) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
               // plan, occasionally with an endpoint outside the grid
               if ($urandom_range(9) == 0)
                  r = req_row(OP_PLAN, $urandom_range(63), $urandom_range(63), $urandom_range(255),
                              $urandom_range(63), $urandom_range(63));
               else
                  r = req_row(OP_PLAN, $urandom_range(w - 1), $urandom_range(h - 1),
                              $urandom_range(255), $urandom_range(w - 1), $urandom_range(h - 1));
            end else if (pick < 50) begin
               r = req_row(OP_READ, $urandom_range(63), $urandom_range(63), $urandom_range(255),
                           $urandom_range(63), $urandom_range(63));
            end else if (pick < 98) begin
               if ($urandom_range(9) < 7)
                  r = req_row(OP_LOAD, $urandom_range(w - 1), $urandom_range(h - 1), rand_occ(),
                              $urandom_range(63), $urandom_range(63));
               else
                  r = req_row(OP_LOAD, $urandom_range(63), $urandom_range(63), rand_occ(),
                              $urandom_range(63), $urandom_range(63));
            end else
               r = req_row(OP_SPARE, $urandom_range(63), $urandom_range(63), $urandom_range(255),
                           $urandom_range(63), $urandom_range(63));
            send_request(r);
         end
      end
      calm = 0;

      // drain and let the block settle
      req_valid <= 0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d plans, %0d path reads and %0d grid loads", plans, reads, loads);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
